// ----- design/ist_pkg.sv -----
// shared types and codes for the interval set table
package ist_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } in_t;

    typedef struct packed {
        logic       covered;
        logic [1:0] status;
        logic [6:0] interval_count;
    } out_t;

    typedef enum logic [2:0] {
        K_ADD,
        K_REMOVE,
        K_QUERY,
        K_BAD,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] lo;
        logic [31:0] hi;
    } job_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_EXTRA,
        S_FINAL,
        S_DONE
    } state_t;

endpackage

// ----- design/ist_front.sv -----
// front end: accepts and classifies items into a two-entry queue
module ist_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ist_pkg::in_t item,
    output logic         busy,
    input  logic         pop,
    output logic         job_valid,
    output ist_pkg::job_t job
);
    import ist_pkg::*;

    localparam int CE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic [31:0] MASK = 32'hFFFF_FFFF >> (32 - CE);

    job_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       in_job;
    logic       push;
    logic       do_pop;

    always_comb
    begin
        in_job.lo = item.range_low & MASK;
        in_job.hi = item.range_high & MASK;
        unique case (item.cmd)
            CMD_ADD:    in_job.kind = K_ADD;
            CMD_REMOVE: in_job.kind = K_REMOVE;
            CMD_QUERY:  in_job.kind = K_QUERY;
            default:    in_job.kind = K_NOP;
        endcase
        if (in_job.kind != K_NOP && in_job.lo >= in_job.hi)
        begin
            in_job.kind = K_BAD;
        end
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign job_valid = (cnt_reg != 2'd0);
    assign do_pop = pop && job_valid;
    assign job = q_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? !wp_reg : wp_reg;
        rp_next = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- design/ist_back.sv -----
// back end: walks the interval table; add and remove rebuild it into the spare bank
module ist_back #(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  ist_pkg::job_t job,
    output logic          pop,
    output logic          done,
    output ist_pkg::out_t result
);
    import ist_pkg::*;

    localparam int CE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] MAXN = CW'(MAX_INTERVALS);

    logic [2*CE-1:0] mem0 [MAX_INTERVALS];
    logic [2*CE-1:0] mem1 [MAX_INTERVALS];

    state_t          st_reg, st_next;
    job_t            job_reg, job_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   n_reg, n_next;
    logic            sel_reg, sel_next;
    logic            dv_reg, dv_next;
    logic            merged_reg, merged_next;
    logic            after_reg, after_next;
    logic            split_reg, split_next;
    logic            cov_reg, cov_next;
    logic [CE-1:0]   mlo_reg, mlo_next;
    logic [CE-1:0]   mhi_reg, mhi_next;
    logic [2*CE-1:0] pend_reg, pend_next;
    logic [2*CE-1:0] rd_reg;
    logic            done_reg, done_next;
    out_t            result_reg, result_next;
    logic            load;
    logic            we;
    logic [2*CE-1:0] wd;
    logic [CE-1:0]   s, e;
    logic [CE-1:0]   lo, hi;
    logic            full;
    logic [31:0]     n_wide;

    assign s = rd_reg[2*CE-1:CE];
    assign e = rd_reg[CE-1:0];
    assign lo = job_reg.lo[CE-1:0];
    assign hi = job_reg.hi[CE-1:0];
    assign done = done_reg;
    assign result = result_reg;

    always_comb
    begin
        st_next = st_reg;
        job_next = job_reg;
        i_next = i_reg;
        k_next = k_reg;
        n_next = n_reg;
        sel_next = sel_reg;
        dv_next = 1'b0;
        merged_next = merged_reg;
        after_next = after_reg;
        split_next = split_reg;
        cov_next = cov_reg;
        mlo_next = mlo_reg;
        mhi_next = mhi_reg;
        pend_next = pend_reg;
        done_next = 1'b0;
        result_next = result_reg;
        load = 1'b0;
        we = 1'b0;
        wd = '0;
        pop = 1'b0;
        full = 1'b0;
        n_wide = 32'(n_reg);
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    job_next = job;
                    i_next = '0;
                    k_next = '0;
                    merged_next = 1'b0;
                    after_next = 1'b0;
                    split_next = 1'b0;
                    cov_next = 1'b0;
                    mlo_next = job.lo[CE-1:0];
                    mhi_next = job.hi[CE-1:0];
                    if (job.kind == K_BAD || job.kind == K_NOP)
                    begin
                        st_next = S_DONE;
                    end
                    else
                    begin
                        st_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (dv_reg)
                begin
                    case (job_reg.kind)
                        K_ADD:
                        begin
                            if (after_reg || (!merged_reg && e < mlo_reg))
                            begin
                                we = 1'b1;
                                wd = rd_reg;
                            end
                            else if (s <= mhi_reg)
                            begin
                                merged_next = 1'b1;
                                if (s < mlo_reg) mlo_next = s;
                                if (e > mhi_reg) mhi_next = e;
                            end
                            else
                            begin
                                we = 1'b1;
                                wd = {mlo_reg, mhi_reg};
                                pend_next = rd_reg;
                                after_next = 1'b1;
                                st_next = S_EXTRA;
                            end
                        end
                        K_REMOVE:
                        begin
                            if (e <= lo || s >= hi)
                            begin
                                we = 1'b1;
                                wd = rd_reg;
                            end
                            else if (s < lo && e > hi)
                            begin
                                we = 1'b1;
                                wd = {s, lo};
                                pend_next = {hi, e};
                                split_next = 1'b1;
                                st_next = S_EXTRA;
                            end
                            else if (s < lo)
                            begin
                                we = 1'b1;
                                wd = {s, lo};
                            end
                            else if (e > hi)
                            begin
                                we = 1'b1;
                                wd = {hi, e};
                            end
                        end
                        default:
                        begin
                            if (s <= lo && e >= hi) cov_next = 1'b1;
                        end
                    endcase
                end
                if (st_next == S_RUN)
                begin
                    if (i_reg < n_reg)
                    begin
                        load = 1'b1;
                        dv_next = 1'b1;
                        i_next = i_reg + 1'b1;
                    end
                    else if (!dv_reg)
                    begin
                        st_next = S_FINAL;
                    end
                end
            end
            S_EXTRA:
            begin
                we = 1'b1;
                wd = pend_reg;
                st_next = S_RUN;
            end
            S_FINAL:
            begin
                if (job_reg.kind == K_ADD && !after_reg)
                begin
                    we = 1'b1;
                    wd = {mlo_reg, mhi_reg};
                end
                st_next = S_DONE;
            end
            S_DONE:
            begin
                result_next.covered = 1'b0;
                result_next.status = ST_OK;
                case (job_reg.kind)
                    K_ADD:    full = !merged_reg && n_reg >= MAXN;
                    K_REMOVE: full = split_reg && n_reg >= MAXN;
                    default:  full = 1'b0;
                endcase
                case (job_reg.kind)
                    K_ADD, K_REMOVE:
                    begin
                        if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            sel_next = !sel_reg;
                            n_next = k_reg;
                            n_wide = 32'(k_reg);
                        end
                    end
                    K_QUERY: result_next.covered = cov_reg;
                    K_BAD:   result_next.status = ST_BAD;
                    default: result_next.status = ST_OK;
                endcase
                result_next.interval_count = n_wide[6:0];
                done_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
        if (we && k_reg >= MAXN)
        begin
            we = 1'b0;
        end
        if (we)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && sel_reg)
        begin
            mem0[k_reg[AW-1:0]] <= wd;
        end
        if (we && !sel_reg)
        begin
            mem1[k_reg[AW-1:0]] <= wd;
        end
        if (load)
        begin
            rd_reg <= sel_reg ? mem1[i_reg[AW-1:0]] : mem0[i_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        mlo_reg <= mlo_next;
        mhi_reg <= mhi_next;
        pend_reg <= pend_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            i_reg <= '0;
            k_reg <= '0;
            n_reg <= '0;
            sel_reg <= 1'b0;
            dv_reg <= 1'b0;
            merged_reg <= 1'b0;
            after_reg <= 1'b0;
            split_reg <= 1'b0;
            cov_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            i_reg <= i_next;
            k_reg <= k_next;
            n_reg <= n_next;
            sel_reg <= sel_next;
            dv_reg <= dv_next;
            merged_reg <= merged_next;
            after_reg <= after_next;
            split_reg <= split_next;
            cov_reg <= cov_next;
            done_reg <= done_next;
        end
    end

endmodule

// ----- design/interval_set_table.sv -----
// top level of the interval set table
//
// an item (cmd, range_low, range_high) is taken at a rising edge with start
// high and busy low. each item gives exactly one result on result, marked by
// done for one cycle; the receiver cannot hold results off.
// the front end checks the range and queues up to two items; busy is high
// while that queue is full.
// the back end keeps the table in two banks of memory: add and remove read
// every stored interval once from one bank and write the new table into the
// other, then swap banks on success. the walk reads the stored intervals in
// turn through the single read port of the bank, and a walk that inserts or
// splits an interval takes an extra write step for the second interval; a
// query takes the same walk, while a rejected range or an unknown command
// skips the walk and goes straight to the done state.
// after reset the table is empty and the queue holds nothing; the banks need
// no clearing since only the first stored_count entries are read.
module interval_set_table #(
    parameter int MAX_INTERVALS = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ist_pkg::in_t  item,
    output logic          busy,
    output logic          done,
    output ist_pkg::out_t result
);
    import ist_pkg::*;

    logic job_valid;
    logic pop;
    job_t job;

    ist_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .pop(pop),
        .job_valid(job_valid),
        .job(job)
    );

    ist_back #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_valid(job_valid),
        .job(job),
        .pop(pop),
        .done(done),
        .result(result)
    );

endmodule

// ----- tb/interval_set_table_tb.sv -----
// testbench for the interval set table: directed table and random items checked against a predictor
module interval_set_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ist_pkg::*;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    in_t  item;
    logic busy;
    logic done;
    out_t result;

    interval_set_table #(
        .MAX_INTERVALS(CAPACITY),
        .COORD_WIDTH(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    logic [31:0] span_lo [CAPACITY];
    logic [31:0] span_hi [CAPACITY];
    int span_count;
    out_t pending_results [$];
    int errors;
    int cycles;

    typedef struct {
        in_t  cmd_item;
        bit   typed;
        out_t typed_result;
    } row_t;

    row_t rows [$];

    function automatic void add_row(in_t it, bit typed, out_t want);
        row_t nr;
        nr.cmd_item = it;
        nr.typed = typed;
        nr.typed_result = want;
        rows = {rows, nr};
    endfunction

    function automatic logic [1:0] apply_add(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] ns [CAPACITY];
        logic [31:0] ne [CAPACITY];
        int i;
        int k;
        int merged;
        i = 0;
        k = 0;
        merged = 0;
        while (i < span_count && span_hi[i] < lo)
        begin
            ns[k] = span_lo[i];
            ne[k] = span_hi[i];
            k++;
            i++;
        end
        while (i < span_count && span_lo[i] <= hi)
        begin
            if (span_lo[i] < lo) lo = span_lo[i];
            if (span_hi[i] > hi) hi = span_hi[i];
            merged++;
            i++;
        end
        if (merged == 0 && span_count >= CAPACITY) return ST_FULL;
        ns[k] = lo;
        ne[k] = hi;
        k++;
        while (i < span_count && k < CAPACITY)
        begin
            ns[k] = span_lo[i];
            ne[k] = span_hi[i];
            k++;
            i++;
        end
        span_lo = ns;
        span_hi = ne;
        span_count = k;
        return ST_OK;
    endfunction

    function automatic logic [1:0] apply_remove(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] ns [CAPACITY];
        logic [31:0] ne [CAPACITY];
        int k;
        k = 0;
        for (int i = 0; i < span_count; i++)
            if (span_lo[i] < lo && span_hi[i] > hi && span_count >= CAPACITY) return ST_FULL;
        for (int i = 0; i < span_count; i++)
        begin
            if (span_hi[i] <= lo || span_lo[i] >= hi)
            begin
                if (k < CAPACITY)
                begin
                    ns[k] = span_lo[i];
                    ne[k] = span_hi[i];
                    k++;
                end
            end
            else
            begin
                if (span_lo[i] < lo && k < CAPACITY)
                begin
                    ns[k] = span_lo[i];
                    ne[k] = lo;
                    k++;
                end
                if (span_hi[i] > hi && k < CAPACITY)
                begin
                    ns[k] = hi;
                    ne[k] = span_hi[i];
                    k++;
                end
            end
        end
        span_lo = ns;
        span_hi = ne;
        span_count = k;
        return ST_OK;
    endfunction

    function automatic out_t predict_table(in_t it);
        out_t r;
        r = '0;
        if (it.cmd != 2'd3)
        begin
            if (it.range_low >= it.range_high) r.status = ST_BAD;
            else if (it.cmd == CMD_ADD) r.status = apply_add(it.range_low, it.range_high);
            else if (it.cmd == CMD_REMOVE) r.status = apply_remove(it.range_low, it.range_high);
            else
                for (int i = 0; i < span_count; i++)
                    if (span_lo[i] <= it.range_low && span_hi[i] >= it.range_high)
                        r.covered = 1'b1;
        end
        r.interval_count = span_count[6:0];
        return r;
    endfunction

    task automatic send_item(in_t it);
        int gap;
        out_t want_next;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        want_next = predict_table(it);
        pending_results = {pending_results, want_next};
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic in_t make_item(logic [1:0] c, logic [31:0] lo, logic [31:0] hi);
        in_t it;
        it.cmd = c;
        it.range_low = lo;
        it.range_high = hi;
        return it;
    endfunction

    function automatic in_t random_item(int window);
        logic [31:0] base;
        logic [31:0] lo;
        logic [31:0] len;
        int sel;
        sel = $urandom_range(0, 99);
        base = (window == 0) ? $urandom : 32'h8000_0000;
        lo = (window == 0) ? $urandom : base + $urandom_range(0, 600);
        len = $urandom_range(1, 40);
        if (sel < 4) return make_item(2'($urandom_range(0, 3)), $urandom, $urandom);
        if (sel < 8) return make_item(2'($urandom_range(0, 2)), lo, lo - $urandom_range(0, 3));
        if (sel < 10) return make_item(2'd3, $urandom, $urandom);
        if (lo > 32'hFFFF_FFFF - len) lo = 32'hFFFF_FFFF - len;
        if (sel < 50) return make_item(CMD_ADD, lo, lo + len);
        if (sel < 75) return make_item(CMD_REMOVE, lo, lo + len);
        return make_item(CMD_QUERY, lo, lo + len);
    endfunction

    always @(posedge clk)
    begin
        out_t want;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.covered !== want.covered)
                begin
                    $error("covered: expected %0d actual %0d", want.covered, result.covered);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, result.status);
                    errors++;
                end
                if (result.interval_count !== want.interval_count)
                begin
                    $error("interval_count: expected %0d actual %0d",
                           want.interval_count, result.interval_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** interval_set_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        out_t got;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        errors = 0;
        cycles = 0;
        span_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(make_item(CMD_QUERY, 32'd0, 32'hFFFF_FFFF), 1'b1, '{1'b0, ST_OK, 7'd0});
        add_row(make_item(CMD_REMOVE, 32'd10, 32'd20), 1'b1, '{1'b0, ST_OK, 7'd0});
        add_row(make_item(CMD_ADD, 32'd5, 32'd5), 1'b1, '{1'b0, ST_BAD, 7'd0});
        add_row(make_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'd0), 1'b1, '{1'b0, ST_BAD, 7'd0});
        add_row(make_item(CMD_QUERY, 32'd7, 32'd3), 1'b1, '{1'b0, ST_BAD, 7'd0});
        add_row(make_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, '{1'b0, ST_OK, 7'd0});
        add_row(make_item(CMD_ADD, 32'd0, 32'd1), 1'b1, '{1'b0, ST_OK, 7'd1});
        add_row(make_item(CMD_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF), 1'b1, '{1'b0, ST_OK, 7'd2});
        add_row(make_item(CMD_ADD, 32'd1, 32'd10), 1'b0, '0);
        add_row(make_item(CMD_ADD, 32'd20, 32'd30), 1'b0, '0);
        add_row(make_item(CMD_ADD, 32'd10, 32'd20), 1'b0, '0);
        add_row(make_item(CMD_QUERY, 32'd0, 32'd30), 1'b0, '0);
        add_row(make_item(CMD_REMOVE, 32'd12, 32'd14), 1'b0, '0);
        add_row(make_item(CMD_QUERY, 32'd0, 32'd30), 1'b0, '0);
        add_row(make_item(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(make_item(CMD_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(make_item(CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA), 1'b0, '0);
        add_row(make_item(CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF), 1'b0, '0);
        foreach (rows[n])
        begin
            r = rows[n];
            send_item(r.cmd_item);
            if (r.typed)
            begin
                got = pending_results[$];
                if (got !== r.typed_result)
                begin
                    $error("typed row %0d: expected %h predicted %h", n, r.typed_result, got);
                    errors++;
                end
            end
        end
        drain_results();

        // fill to capacity with spaced two-wide intervals, then provoke full rejections
        for (int n = 0; n < CAPACITY; n++)
            send_item(make_item(CMD_ADD, 32'h1000 + 4 * n, 32'h1002 + 4 * n));
        send_item(make_item(CMD_ADD, 32'h0000_0100, 32'h0000_0200));
        send_item(make_item(CMD_REMOVE, 32'h1000, 32'h1001 + 0));
        send_item(make_item(CMD_ADD, 32'h1000, 32'h1001));
        send_item(make_item(CMD_REMOVE, 32'h1004, 32'h1005));
        send_item(make_item(CMD_ADD, 32'h1002, 32'h1004));
        send_item(make_item(CMD_REMOVE, 32'h1001, 32'h1002));
        send_item(make_item(CMD_ADD, 32'h0000_0100, 32'h0000_0200));
        send_item(make_item(CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF));
        drain_results();

        for (int n = 0; n < 660; n++)
        begin
            send_item(random_item((n % 200) < 170 ? 1 : 0));
            if (n == 300) drain_results();
        end
        drain_results();
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("** interval_set_table: PASSED **");
        else
            $display("** interval_set_table: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
design/ist_pkg.sv
design/ist_front.sv
design/ist_back.sv
design/interval_set_table.sv
tb/interval_set_table_tb.sv
